// ----- src/tfmm_pkg.sv -----
// Shared types, constants and codes for the ternary factor min-marginal engine.
// No dependencies.
package tfmm_pkg;

    localparam int MAX_LABELS = 16;
    localparam int LBL_W      = $clog2(MAX_LABELS);
    localparam int ADDR_W     = 2 * LBL_W;
    localparam int DEPTH      = MAX_LABELS * MAX_LABELS;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int COST_W     = 34;
    localparam int QDEPTH     = 2;

    typedef enum logic [2:0] {
        CMD_WR_A  = 3'd0,
        CMD_WR_B  = 3'd1,
        CMD_WR_C  = 3'd2,
        CMD_LB    = 3'd3,
        CMD_MM12  = 3'd4,
        CMD_MM13  = 3'd5,
        CMD_MM23  = 3'd6,
        CMD_COMPL = 3'd7
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_LABELS_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LABELS_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LABELS_THIRD  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [3:0]         label_one;
        logic [3:0]         label_two;
        logic [3:0]         label_three;
        logic               known_one;
        logic               known_two;
        logic               known_three;
        logic signed [31:0] cost_value;
    } t_in_word;

    typedef struct packed {
        logic signed [COST_W-1:0] total_cost;
        logic [3:0]               best_one;
        logic [3:0]               best_two;
        logic [3:0]               best_three;
        logic                     infinite_flag;
        logic                     error_flag;
    } t_out_word;

    // Classified job passed from front to back.
    typedef enum logic [1:0] {
        JOB_WRITE  = 2'd0,
        JOB_SEARCH = 2'd1,
        JOB_DIRECT = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [2:0]         cmd;
        logic [LBL_W-1:0]   lo1, lo2, lo3;
        logic [CNT_W-1:0]   hi1, hi2, hi3;
        logic               zero_best;
        logic               store_ok;
        logic signed [31:0] cost_value;
        t_out_word          direct;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_ACC,
        ST_OUT
    } t_state;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r);
        if (r == '0) return CNT_W'(1);
        if (r > CNT_W'(MAX_LABELS)) return CNT_W'(MAX_LABELS);
        return r;
    endfunction

endpackage

// ----- src/tfmm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tfmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/tfmm_front.sv -----
// Front end: accepts input words, classifies them into jobs, queues them.
// Depends on tfmm_pkg.
module tfmm_front
    import tfmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_word         i_in,
    input  logic [CNT_W-1:0] i_n1,
    input  logic [CNT_W-1:0] i_n2,
    input  logic [CNT_W-1:0] i_n3,
    output logic             o_job_valid,
    output t_job             o_job,
    input  logic             i_job_take
);
    t_job r_q [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QDEPTH):0]   r_cnt;
    t_job job;
    logic ok1, ok2, ok3, do_push, do_pop;
    logic [CNT_W-1:0] l1, l2, l3;

    assign l1 = CNT_W'(i_in.label_one);
    assign l2 = CNT_W'(i_in.label_two);
    assign l3 = CNT_W'(i_in.label_three);
    assign ok1 = l1 < i_n1;
    assign ok2 = l2 < i_n2;
    assign ok3 = l3 < i_n3;

    always_comb begin
        job            = '0;
        job.cmd        = i_in.cmd;
        job.cost_value = i_in.cost_value;
        job.kind       = JOB_SEARCH;
        job.zero_best  = 1'b1;
        job.store_ok   = 1'b1;
        job.lo1 = '0; job.lo2 = '0; job.lo3 = '0;
        job.hi1 = i_n1; job.hi2 = i_n2; job.hi3 = i_n3;
        case (t_cmd'(i_in.cmd))
            CMD_WR_A, CMD_WR_B, CMD_WR_C: begin
                job.kind = JOB_WRITE;
                job.lo1  = i_in.label_one;
                job.lo2  = i_in.label_two;
                job.lo3  = i_in.label_three;
            end
            CMD_LB: begin
            end
            CMD_MM12: begin
                job.lo1 = i_in.label_one; job.hi1 = l1 + CNT_W'(1);
                job.lo2 = i_in.label_two; job.hi2 = l2 + CNT_W'(1);
                if (!(ok1 && ok2)) begin
                    job.kind = JOB_DIRECT;
                    job.direct.error_flag = 1'b1;
                end
            end
            CMD_MM13: begin
                job.lo1 = i_in.label_one;   job.hi1 = l1 + CNT_W'(1);
                job.lo3 = i_in.label_three; job.hi3 = l3 + CNT_W'(1);
                if (!(ok1 && ok3)) begin
                    job.kind = JOB_DIRECT;
                    job.direct.error_flag = 1'b1;
                end
            end
            CMD_MM23: begin
                job.lo2 = i_in.label_two;   job.hi2 = l2 + CNT_W'(1);
                job.lo3 = i_in.label_three; job.hi3 = l3 + CNT_W'(1);
                if (!(ok2 && ok3)) begin
                    job.kind = JOB_DIRECT;
                    job.direct.error_flag = 1'b1;
                end
            end
            default: begin
                job.zero_best = 1'b0;
                if (i_in.known_one) begin
                    job.lo1 = i_in.label_one; job.hi1 = l1 + CNT_W'(1);
                end
                if (i_in.known_two) begin
                    job.lo2 = i_in.label_two; job.hi2 = l2 + CNT_W'(1);
                end
                if (i_in.known_three) begin
                    job.lo3 = i_in.label_three; job.hi3 = l3 + CNT_W'(1);
                end
                if (i_in.known_one && i_in.known_two && i_in.known_three) begin
                    if (!(ok1 && ok2 && ok3)) begin
                        job.kind = JOB_DIRECT;
                        job.direct.infinite_flag = 1'b1;
                        job.direct.best_one   = i_in.label_one;
                        job.direct.best_two   = i_in.label_two;
                        job.direct.best_three = i_in.label_three;
                    end
                end else if ((i_in.known_one && !ok1) || (i_in.known_two && !ok2)
                             || (i_in.known_three && !ok3)) begin
                    job.kind = JOB_DIRECT;
                    job.direct.error_flag = 1'b1;
                end
            end
        endcase
    end

    assign full        = r_cnt == ($clog2(QDEPTH)+1)'(QDEPTH);
    assign do_push     = push && !full;
    assign o_job_valid = r_cnt != '0;
    assign do_pop      = i_job_take && o_job_valid;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + ($clog2(QDEPTH)+1)'(do_push) - ($clog2(QDEPTH)+1)'(do_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !do_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !do_pop) else $error("queue underflow");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ($clog2(QDEPTH)+1)'(QDEPTH)) else $error("queue count out of range");
`endif
endmodule

// ----- src/tfmm_back.sv -----
// Back end: table storage, clearing pass, triple search and result register.
// Depends on tfmm_pkg and tfmm_ram.
module tfmm_back
    import tfmm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_take,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_out
);
    t_state r_state, n_state;
    logic [ADDR_W:0]  r_clr;
    logic [LBL_W-1:0] r_x1, r_x2, r_x3;
    logic [LBL_W-1:0] r_p1, r_p2, r_p3;
    logic             r_found;
    logic signed [COST_W-1:0] r_best;
    logic [LBL_W-1:0] r_b1, r_b2, r_b3;
    t_out_word r_out;
    logic      r_full;
    logic      r_last;

    logic we_a, we_b, we_c, clearing;
    logic [ADDR_W-1:0] ra_a, ra_b, ra_c;
    logic [31:0] wd, rd_a, rd_b, rd_c;
    logic signed [COST_W-1:0] sum;
    logic last_x3, last_x2, last_x1, take, load_out;
    t_out_word res;

    assign clearing = r_state == ST_CLEAR;
    assign wd       = clearing ? 32'd0 : i_job.cost_value;
    assign take     = (r_state == ST_IDLE) && i_job_valid && !r_full;
    assign o_job_take = take;
    assign we_a = clearing || (take && i_job.kind == JOB_WRITE && i_job.cmd == CMD_WR_A);
    assign we_b = clearing || (take && i_job.kind == JOB_WRITE && i_job.cmd == CMD_WR_B);
    assign we_c = clearing || (take && i_job.kind == JOB_WRITE && i_job.cmd == CMD_WR_C);
    assign ra_a = {r_x1, r_x2};
    assign ra_b = {r_x1, r_x3};
    assign ra_c = {r_x2, r_x3};

    logic [ADDR_W-1:0] wr_addr;
    always_comb begin
        case (t_cmd'(i_job.cmd))
            CMD_WR_A: wr_addr = {i_job.lo1, i_job.lo2};
            CMD_WR_B: wr_addr = {i_job.lo1, i_job.lo3};
            default:  wr_addr = {i_job.lo2, i_job.lo3};
        endcase
    end

    tfmm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(clearing ? r_clr[ADDR_W-1:0] : wr_addr),
        .i_wdata(wd), .i_raddr(ra_a), .o_rdata(rd_a));
    tfmm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(clearing ? r_clr[ADDR_W-1:0] : wr_addr),
        .i_wdata(wd), .i_raddr(ra_b), .o_rdata(rd_b));
    tfmm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_c (
        .i_clk(i_clk), .i_we(we_c), .i_waddr(clearing ? r_clr[ADDR_W-1:0] : wr_addr),
        .i_wdata(wd), .i_raddr(ra_c), .o_rdata(rd_c));

    t_job r_job;
    assign last_x3 = CNT_W'(r_x3) + CNT_W'(1) >= r_job.hi3;
    assign last_x2 = CNT_W'(r_x2) + CNT_W'(1) >= r_job.hi2;
    assign last_x1 = CNT_W'(r_x1) + CNT_W'(1) >= r_job.hi1;
    assign sum = COST_W'(signed'(rd_a)) + COST_W'(signed'(rd_b)) + COST_W'(signed'(rd_c));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == (ADDR_W+1)'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (take && i_job.kind == JOB_SEARCH) n_state = ST_READ;
            ST_READ:  n_state = ST_ACC;
            ST_ACC:   if (r_last) n_state = ST_OUT;
            ST_OUT:   if (!r_full) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        res = '0;
        load_out = 1'b0;
        if (take && i_job.kind == JOB_DIRECT) begin
            res = i_job.direct;
            load_out = 1'b1;
        end else if (take && i_job.kind == JOB_WRITE) begin
            load_out = 1'b1;
        end else if (r_state == ST_OUT && !r_full) begin
            res.total_cost = r_best;
            if (!r_job.zero_best) begin
                res.best_one   = r_b1;
                res.best_two   = r_b2;
                res.best_three = r_b3;
            end
            load_out = 1'b1;
        end
    end

    assign empty = !r_full;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
            r_x1 <= i_job.lo1; r_x2 <= i_job.lo2; r_x3 <= i_job.lo3;
        end else if (r_state == ST_READ || (r_state == ST_ACC && !r_last)) begin
            r_p1 <= r_x1; r_p2 <= r_x2; r_p3 <= r_x3;
            if (!last_x3) begin
                r_x3 <= r_x3 + 1'b1;
            end else begin
                r_x3 <= r_job.lo3;
                if (!last_x2) begin
                    r_x2 <= r_x2 + 1'b1;
                end else begin
                    r_x2 <= r_job.lo2;
                    r_x1 <= r_x1 + 1'b1;
                end
            end
        end
        if (r_state == ST_ACC && (!r_found || sum < r_best)) begin
            r_best <= sum;
            r_b1 <= r_p1; r_b2 <= r_p2; r_b3 <= r_p3;
        end
        if (load_out) r_out <= res;
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_full     <= 1'b0;
            r_found    <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
            if (load_out) r_full <= 1'b1;
            else if (pop && r_full) r_full <= 1'b0;
            if (take) begin
                r_found    <= 1'b0;
                r_last     <= 1'b0;
            end else begin
                if (r_state == ST_ACC) r_found <= 1'b1;
                if (r_state == ST_READ || r_state == ST_ACC) begin
                    if (!r_last) r_last <= last_x1 && last_x2 && last_x3;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> (r_state == ST_IDLE) && !r_full) else $error("job taken while busy");
    a_no_write_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> !we_a && !we_b && !we_c) else $error("write during search");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !pop) |=> r_full && $stable(r_out)) else $error("result lost");
`endif
endmodule

// ----- src/ternary_factor_min_marginal_engine.sv -----
// Top level of the ternary factor min-marginal engine: config registers, front, back.
// Depends on tfmm_pkg, tfmm_front, tfmm_back.
//
// After reset the block clears its three 256-entry tables; the input queue takes two
// words during clearing and full then stays high until clearing ends. Table writes and
// out-of-range queries go from the queue straight to the result register, with no
// search. A search reads one label triple per cycle from the three table RAMs, over
// every triple in the job's label ranges. A new job starts only after the previous
// result is popped.
// A two-entry queue separates input acceptance from the search unit.
module ternary_factor_min_marginal_engine
    import tfmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_word             i_in,
    output logic                 empty,
    input  logic                 pop,
    output t_out_word            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);
    logic [CNT_W-1:0] r_lab1, r_lab2, r_lab3;
    logic job_valid, job_take, q_full;
    t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lab1 <= CNT_W'(MAX_LABELS);
            r_lab2 <= CNT_W'(MAX_LABELS);
            r_lab3 <= CNT_W'(MAX_LABELS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LABELS_FIRST:  r_lab1 <= i_cfg_data;
                CFG_LABELS_SECOND: r_lab2 <= i_cfg_data;
                CFG_LABELS_THIRD:  r_lab3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full = q_full;

    tfmm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(q_full), .i_in(i_in),
        .i_n1(eff_count(r_lab1)), .i_n2(eff_count(r_lab2)), .i_n3(eff_count(r_lab3)),
        .o_job_valid(job_valid), .o_job(job), .i_job_take(job_take));

    tfmm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job),
        .o_job_take(job_take), .empty(empty), .pop(pop), .o_out(o_out));
endmodule

// ----- sim/tb.sv -----
// Self-checking bench for ternary_factor_min_marginal_engine: random and directed commands,
// expected words computed from a local model of the three cost tables and label counts.
// Depends on tfmm_pkg and the engine RTL.
module tb;
    import tfmm_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_in_word             i_in = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_out_word            o_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CNT_W-1:0]     i_cfg_data = '0;

    ternary_factor_min_marginal_engine dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic signed [31:0] cost_a [DEPTH];
    logic signed [31:0] cost_b [DEPTH];
    logic signed [31:0] cost_c [DEPTH];
    logic [CNT_W-1:0]   count_reg [3];

    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        words_sent = 0;
    longint    cycles = 0;
    int        stall_cycles = 0;
    int        drive_gap = 0;
    int        pop_gap = 0;
    bit        drive_hold = 1'b0;

    function automatic int used_count(input logic [CNT_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_LABELS) return MAX_LABELS;
        return int'(r);
    endfunction

    function automatic longint triple_sum(input int x1, input int x2, input int x3);
        return longint'(cost_a[x1 * MAX_LABELS + x2]) + longint'(cost_b[x1 * MAX_LABELS + x3])
             + longint'(cost_c[x2 * MAX_LABELS + x3]);
    endfunction

    function automatic t_out_word predict_word(input t_in_word w);
        t_out_word r;
        int n1, n2, n3, lo1, hi1, lo2, hi2, lo3, hi3, b1, b2, b3;
        longint best, c;
        bit found, do_search, zero_best;
        r = '0;
        n1 = used_count(count_reg[0]);
        n2 = used_count(count_reg[1]);
        n3 = used_count(count_reg[2]);
        lo1 = 0; hi1 = n1; lo2 = 0; hi2 = n2; lo3 = 0; hi3 = n3;
        do_search = 1'b0;
        zero_best = 1'b1;
        case (t_cmd'(w.cmd))
            CMD_WR_A: cost_a[{w.label_one, w.label_two}] = w.cost_value;
            CMD_WR_B: cost_b[{w.label_one, w.label_three}] = w.cost_value;
            CMD_WR_C: cost_c[{w.label_two, w.label_three}] = w.cost_value;
            CMD_LB: do_search = 1'b1;
            CMD_MM12: begin
                if (w.label_one < n1 && w.label_two < n2) begin
                    do_search = 1'b1;
                    lo1 = w.label_one; hi1 = lo1 + 1; lo2 = w.label_two; hi2 = lo2 + 1;
                end else r.error_flag = 1'b1;
            end
            CMD_MM13: begin
                if (w.label_one < n1 && w.label_three < n3) begin
                    do_search = 1'b1;
                    lo1 = w.label_one; hi1 = lo1 + 1; lo3 = w.label_three; hi3 = lo3 + 1;
                end else r.error_flag = 1'b1;
            end
            CMD_MM23: begin
                if (w.label_two < n2 && w.label_three < n3) begin
                    do_search = 1'b1;
                    lo2 = w.label_two; hi2 = lo2 + 1; lo3 = w.label_three; hi3 = lo3 + 1;
                end else r.error_flag = 1'b1;
            end
            default: begin
                if (w.known_one && w.known_two && w.known_three) begin
                    r.best_one = w.label_one;
                    r.best_two = w.label_two;
                    r.best_three = w.label_three;
                    if (w.label_one < n1 && w.label_two < n2 && w.label_three < n3)
                        r.total_cost = COST_W'(triple_sum(w.label_one, w.label_two,
                                                          w.label_three));
                    else r.infinite_flag = 1'b1;
                end else if ((w.known_one && w.label_one >= n1) ||
                             (w.known_two && w.label_two >= n2) ||
                             (w.known_three && w.label_three >= n3)) begin
                    r.error_flag = 1'b1;
                end else begin
                    do_search = 1'b1;
                    zero_best = 1'b0;
                    if (w.known_one) begin lo1 = w.label_one; hi1 = lo1 + 1; end
                    if (w.known_two) begin lo2 = w.label_two; hi2 = lo2 + 1; end
                    if (w.known_three) begin lo3 = w.label_three; hi3 = lo3 + 1; end
                end
            end
        endcase
        if (do_search) begin
            found = 1'b0;
            best = 0;
            b1 = lo1; b2 = lo2; b3 = lo3;
            for (int x1 = lo1; x1 < hi1; x1++)
                for (int x2 = lo2; x2 < hi2; x2++)
                    for (int x3 = lo3; x3 < hi3; x3++) begin
                        c = triple_sum(x1, x2, x3);
                        if (!found || c < best) begin
                            found = 1'b1; best = c; b1 = x1; b2 = x2; b3 = x3;
                        end
                    end
            r.total_cost = COST_W'(best);
            if (!zero_best) begin
                r.best_one = 4'(b1); r.best_two = 4'(b2); r.best_three = 4'(b3);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] random_cost();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 3) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word random_word(input bit heavy_ok);
        t_in_word w;
        w = '0;
        w.label_one = 4'($urandom);
        w.label_two = 4'($urandom);
        w.label_three = 4'($urandom);
        w.known_one = 1'($urandom);
        w.known_two = 1'($urandom);
        w.known_three = 1'($urandom);
        w.cost_value = random_cost();
        w.cmd = $urandom_range(0, 9) < 5 ? 3'($urandom_range(0, 2)) : 3'($urandom_range(3, 7));
        if (!heavy_ok && (w.cmd == CMD_LB || w.cmd == CMD_COMPL)) w.known_one = 1'b1;
        return w;
    endfunction

    function automatic t_in_word make_word(input t_cmd c, input int l1, input int l2,
                                           input int l3, input logic [2:0] known,
                                           input logic [31:0] v);
        t_in_word w;
        w.cmd = c;
        w.label_one = 4'(l1);
        w.label_two = 4'(l2);
        w.label_three = 4'(l3);
        {w.known_one, w.known_two, w.known_three} = known;
        w.cost_value = v;
        return w;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                expected_words.push_back(predict_word(i_in));
                words_sent <= words_sent + 1;
            end
            if (push && full) begin
            end else if (drive_gap > 0) begin
                drive_gap <= drive_gap - 1;
                push <= 1'b0;
            end else if (!drive_hold && pending_words.size() > 0) begin
                i_in <= pending_words.pop_front();
                push <= 1'b1;
                drive_gap <= $urandom_range(0, 4) * $urandom_range(0, 1);
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen <= results_seen + 1;
                if (expected_words.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected word %h", o_out);
                end else begin
                    e = expected_words.pop_front();
                    if (e !== o_out) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp cost %0d b %0d %0d %0d inf %b err %b, got cost %0d b %0d %0d %0d inf %b err %b",
                                     e.total_cost, e.best_one, e.best_two, e.best_three,
                                     e.infinite_flag, e.error_flag, o_out.total_cost,
                                     o_out.best_one, o_out.best_two, o_out.best_three,
                                     o_out.infinite_flag, o_out.error_flag);
                    end
                end
            end
            if (stall_cycles > 0) begin
                stall_cycles <= stall_cycles - 1;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end else if (pop && !empty) begin
                pop_gap <= $urandom_range(0, 4) * $urandom_range(0, 1);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        count_reg[idx] = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || push || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (4200) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            cost_a[i] = 0; cost_b[i] = 0; cost_c[i] = 0;
        end
        for (int i = 0; i < 3; i++) count_reg[i] = CNT_W'(16);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_words.push_back(make_word(CMD_LB, 0, 0, 0, 3'b000, 0));
        pending_words.push_back(make_word(CMD_WR_A, 15, 15, 0, 3'b000, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(CMD_WR_B, 0, 0, 15, 3'b000, 32'h8000_0000));
        pending_words.push_back(make_word(CMD_WR_C, 15, 15, 15, 3'b000, 32'hFFFF_0000));
        pending_words.push_back(make_word(CMD_WR_A, 0, 0, 0, 3'b000, 32'h8000_0000));
        pending_words.push_back(make_word(CMD_WR_C, 0, 15, 15, 3'b000, 32'h8000_0000));
        pending_words.push_back(make_word(CMD_MM12, 15, 15, 0, 3'b000, 0));
        pending_words.push_back(make_word(CMD_MM13, 0, 0, 15, 3'b000, 0));
        pending_words.push_back(make_word(CMD_MM23, 15, 0, 15, 3'b000, 0));
        pending_words.push_back(make_word(CMD_COMPL, 15, 15, 15, 3'b111, 0));
        pending_words.push_back(make_word(CMD_COMPL, 3, 0, 9, 3'b101, 0));
        pending_words.push_back(make_word(CMD_COMPL, 0, 0, 0, 3'b000, 0));
        drain();

        write_count(CFG_LABELS_FIRST, 5'd0);
        write_count(CFG_LABELS_SECOND, 5'd31);
        write_count(CFG_LABELS_THIRD, 5'd3);
        pending_words.push_back(make_word(CMD_MM12, 1, 2, 0, 3'b000, 0));
        pending_words.push_back(make_word(CMD_MM13, 0, 0, 3, 3'b000, 0));
        pending_words.push_back(make_word(CMD_MM23, 0, 15, 2, 3'b000, 0));
        pending_words.push_back(make_word(CMD_COMPL, 1, 4, 2, 3'b111, 0));
        pending_words.push_back(make_word(CMD_COMPL, 0, 4, 5, 3'b001, 0));
        pending_words.push_back(make_word(CMD_COMPL, 0, 4, 2, 3'b011, 0));
        pending_words.push_back(make_word(CMD_LB, 0, 0, 0, 3'b000, 0));
        for (int i = 0; i < 20; i++) pending_words.push_back(random_word(1'b1));
        stall_cycles = 300;
        drain();

        drive_hold = 1'b1;
        write_count(CFG_LABELS_FIRST, 5'd4);
        write_count(CFG_LABELS_SECOND, 5'd3);
        write_count(CFG_LABELS_THIRD, 5'd16);
        for (int i = 0; i < 50; i++) pending_words.push_back(random_word(1'b1));
        drive_hold = 1'b0;
        drain();

        write_count(CFG_LABELS_FIRST, 5'd16);
        write_count(CFG_LABELS_SECOND, 5'd16);
        write_count(CFG_LABELS_THIRD, 5'd1);
        for (int i = 0; i < 50; i++) pending_words.push_back(random_word(1'b0));
        pending_words.push_back(make_word(CMD_LB, 0, 0, 0, 3'b000, 0));
        drain();

        $display("covered %0d words, %0d results, four label-count settings", words_sent,
                 results_seen);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/tfmm_pkg.sv
src/tfmm_ram.sv
src/tfmm_front.sv
src/tfmm_back.sv
src/ternary_factor_min_marginal_engine.sv
sim/tb.sv
